[hdl/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the servo command shaper: limits, register
// indexes, the configuration record and the multiply/divide unit handshake.
// ----------------------------------------------------------------------------
package scs_pkg;

    // Steering geometry and shaping constants (microseconds)
    localparam int STEER_LIMIT_LOW  = 1000;
    localparam int STEER_LIMIT_HIGH = 2000;
    localparam int CENTER_MARGIN    = 20;
    localparam int CENTER_LO        = STEER_LIMIT_LOW + CENTER_MARGIN;
    localparam int CENTER_HI        = STEER_LIMIT_HIGH - CENTER_MARGIN;
    localparam int TRIM_STEP_US     = 5;
    localparam int HOLD_BAND_US     = 8;
    localparam int MAX_SLEW_US      = 40;
    localparam int PCT_MAX          = 100;

    // Reset values of the configuration registers
    localparam logic [11:0] RST_STEER_CENTER = 12'd1500;
    localparam logic [6:0]  RST_RANGE_PCT    = 7'd100;
    localparam logic [11:0] RST_ESC_REVERSE  = 12'd1000;
    localparam logic [11:0] RST_ESC_NEUTRAL  = 12'd1500;
    localparam logic [11:0] RST_ESC_FORWARD  = 12'd2000;
    localparam logic [11:0] RST_APPLIED      = 12'd1500;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTER  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_TRIM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_RANGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_RANGE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_BIDIR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_REVERSE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_NEUTRAL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_FORWARD   = 3'd7;
    localparam int CFG_DATA_W = 12;

    // Multiply/divide-by-100 unit widths
    localparam int OPA_W       = 13;
    localparam int OPB_W       = 8;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int RECIP_W     = 20;
    localparam int SCALED_W    = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_100   = 671089;  // ceil(2^26 / 100), exact for |a*b| < 1.8M
    localparam int QUO_W       = 14;

    typedef struct packed {
        logic [11:0]        steer_center_us;
        logic signed [6:0]  steer_trim;
        logic [6:0]         left_range_pct;
        logic [6:0]         right_range_pct;
        logic               esc_two_way;
        logic [11:0]        esc_reverse_max_us;
        logic [11:0]        esc_idle_us;
        logic [11:0]        esc_forward_max_us;
    } scs_cfg_t;

    typedef struct packed {
        logic                     start;
        logic signed [OPA_W-1:0]  a;
        logic signed [OPB_W-1:0]  b;
    } scs_mreq_t;

    typedef struct packed {
        logic                     done;
        logic signed [QUO_W-1:0]  quo;
    } scs_mrsp_t;

endpackage

[hdl/servo_command_shaper.sv]
// ----------------------------------------------------------------------------
// servo_command_shaper
// Steering and throttle shaping: center/trim, per-side travel, hold band and
// slew limit for steering, piecewise or forward-only ESC mapping for throttle.
// ----------------------------------------------------------------------------
// The sequencer makes three passes through the shared multiply/divide-by-100
// unit (issue plus 3-stage pipe each) and takes a new item only once back in idle.
// A finished result waits in the output register while the next item enters.
// Reset (rst_n, asynchronous, active low): registers to their defaults,
// applied steering pulse to 1500 us, no result pending.
module servo_command_shaper
    import scs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items: [7:0] throttle_pct, [15:8] steer_pct
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,
    // result items: [11:0] steer_pulse_us, [12] steer_changed,
    // [24:13] esc_pulse_us, [31:25] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_TRAVEL,
        ST_TARGET,
        ST_ESC,
        ST_FINISH
    } state_t;

    scs_cfg_t  cfg;
    scs_mreq_t req_reg;
    scs_mreq_t req_next;
    scs_mrsp_t rsp;

    state_t state_reg, state_next;

    logic signed [7:0] thr_reg, thr_next;
    logic signed [7:0] str_reg, str_next;
    logic [11:0]       center_reg, center_next;
    logic [11:0]       applied_reg, applied_next;
    logic              changed_reg, changed_next;
    logic [11:0]       esc_reg, esc_next;
    logic              m_valid_reg, m_valid_next;
    logic [31:0]       m_data_reg, m_data_next;

    // command clamp
    logic signed [7:0]  thr_raw, str_raw, thr_clamp, str_clamp;
    // center and travel
    logic signed [13:0] center_raw;
    logic [11:0]        center_w;
    logic signed [12:0] span_left, span_right;
    logic signed [7:0]  pct_left, pct_right;
    // target, hold band and slew
    logic signed [13:0] target_raw;
    logic [11:0]        target_w;
    logic signed [12:0] delta_w;
    logic               move_w;
    logic signed [12:0] step_w;
    logic signed [13:0] sum_w;
    logic [11:0]        applied_w;
    // throttle
    logic               thr_neg;
    logic signed [12:0] diff_fwd, diff_rev;
    logic signed [13:0] esc_sum;

    scs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scs_muldiv100 u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    // Datapath around the shared unit
    always_comb
    begin
        // clamp both commands to -100..100
        thr_raw   = $signed(s_tdata[7:0]);
        str_raw   = $signed(s_tdata[15:8]);
        thr_clamp = (thr_raw < -8'(PCT_MAX)) ? -8'(PCT_MAX) :
                    (thr_raw >  8'(PCT_MAX)) ?  8'(PCT_MAX) : thr_raw;
        str_clamp = (str_raw < -8'(PCT_MAX)) ? -8'(PCT_MAX) :
                    (str_raw >  8'(PCT_MAX)) ?  8'(PCT_MAX) : str_raw;

        // trimmed center, held 20 us inside the limits
        center_raw = $signed({2'b00, cfg.steer_center_us})
                   + 14'(cfg.steer_trim) * 14'(TRIM_STEP_US);
        if (center_raw < 14'(CENTER_LO))
            center_w = 12'(CENTER_LO);
        else if (center_raw > 14'(CENTER_HI))
            center_w = 12'(CENTER_HI);
        else
            center_w = center_raw[11:0];

        span_left  = $signed({1'b0, center_w}) - 13'(STEER_LIMIT_LOW);
        span_right = 13'(STEER_LIMIT_HIGH) - $signed({1'b0, center_w});
        pct_left   = (cfg.left_range_pct > 7'(PCT_MAX)) ? 8'(PCT_MAX)
                                                         : $signed({1'b0, cfg.left_range_pct});
        pct_right  = (cfg.right_range_pct > 7'(PCT_MAX)) ? 8'(PCT_MAX)
                                                          : $signed({1'b0, cfg.right_range_pct});

        // target from the unit result, kept within the limits
        target_raw = $signed({2'b00, center_reg}) + rsp.quo;
        if (target_raw < 14'(STEER_LIMIT_LOW))
            target_w = 12'(STEER_LIMIT_LOW);
        else if (target_raw > 14'(STEER_LIMIT_HIGH))
            target_w = 12'(STEER_LIMIT_HIGH);
        else
            target_w = target_raw[11:0];

        // move only outside the hold band, by at most the slew step
        delta_w = $signed({1'b0, target_w}) - $signed({1'b0, applied_reg});
        move_w  = (delta_w > 13'(HOLD_BAND_US)) || (delta_w < -13'(HOLD_BAND_US));
        if (delta_w > 13'(MAX_SLEW_US))
            step_w = 13'(MAX_SLEW_US);
        else if (delta_w < -13'(MAX_SLEW_US))
            step_w = -13'(MAX_SLEW_US);
        else
            step_w = delta_w;
        sum_w = $signed({2'b00, applied_reg}) + 14'(step_w);
        if (sum_w < 14'(STEER_LIMIT_LOW))
            applied_w = 12'(STEER_LIMIT_LOW);
        else if (sum_w > 14'(STEER_LIMIT_HIGH))
            applied_w = 12'(STEER_LIMIT_HIGH);
        else
            applied_w = sum_w[11:0];

        // throttle spans on either side of neutral
        thr_neg  = thr_reg[7];
        diff_fwd = $signed({1'b0, cfg.esc_forward_max_us})
                 - $signed({1'b0, cfg.esc_idle_us});
        diff_rev = $signed({1'b0, cfg.esc_idle_us})
                 - $signed({1'b0, cfg.esc_reverse_max_us});
        esc_sum  = $signed({2'b00, cfg.esc_idle_us}) + rsp.quo;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        thr_next     = thr_reg;
        str_next     = str_reg;
        center_next  = center_reg;
        applied_next = applied_reg;
        changed_next = changed_reg;
        esc_next     = esc_reg;
        req_next     = req_reg;
        req_next.start = 1'b0;
        m_data_next  = m_data_reg;
        // drop the pending result once taken
        m_valid_next = m_valid_reg & ~m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    thr_next   = thr_clamp;
                    str_next   = str_clamp;
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                // travel of the side the command points to
                center_next    = center_w;
                req_next.start = 1'b1;
                req_next.a     = str_reg[7] ? span_left : span_right;
                req_next.b     = str_reg[7] ? pct_left  : pct_right;
                state_next     = ST_TRAVEL;
            end
            ST_TRAVEL:
            begin
                if (rsp.done)
                begin
                    req_next.start = 1'b1;
                    req_next.a     = 13'(rsp.quo);
                    req_next.b     = str_reg;
                    state_next     = ST_TARGET;
                end
            end
            ST_TARGET:
            begin
                if (rsp.done)
                begin
                    changed_next = move_w;
                    if (move_w)
                        applied_next = applied_w;
                    // forward-only mode treats reverse throttle as zero
                    req_next.start = 1'b1;
                    req_next.a     = (cfg.esc_two_way && thr_neg) ? diff_rev : diff_fwd;
                    req_next.b     = (!cfg.esc_two_way && thr_neg) ? '0 : thr_reg;
                    state_next     = ST_ESC;
                end
            end
            ST_ESC:
            begin
                if (rsp.done)
                begin
                    esc_next   = esc_sum[11:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, esc_reg, changed_reg, applied_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            applied_reg <= RST_APPLIED;
            req_reg     <= '0;
            m_valid_reg <= 1'b0;
            thr_reg     <= '0;
            str_reg     <= '0;
            center_reg  <= '0;
            changed_reg <= 1'b0;
            esc_reg     <= '0;
            m_data_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            applied_reg <= applied_next;
            req_reg     <= req_next;
            m_valid_reg <= m_valid_next;
            thr_reg     <= thr_next;
            str_reg     <= str_next;
            center_reg  <= center_next;
            changed_reg <= changed_next;
            esc_reg     <= esc_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hdl/scs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// scs_cfg_regs
// Configuration register file: decodes the write port into the settings record.
// ----------------------------------------------------------------------------
module scs_cfg_regs
    import scs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output scs_cfg_t              cfg
);

    scs_cfg_t cfg_reg;
    scs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEER_CENTER: cfg_next.steer_center_us    = cfg_wdata;
                REG_STEER_TRIM:   cfg_next.steer_trim         = $signed(cfg_wdata[6:0]);
                REG_LEFT_RANGE:   cfg_next.left_range_pct     = cfg_wdata[6:0];
                REG_RIGHT_RANGE:  cfg_next.right_range_pct    = cfg_wdata[6:0];
                REG_ESC_BIDIR:    cfg_next.esc_two_way        = cfg_wdata[0];
                REG_ESC_REVERSE:  cfg_next.esc_reverse_max_us = cfg_wdata;
                REG_ESC_NEUTRAL:  cfg_next.esc_idle_us        = cfg_wdata;
                REG_ESC_FORWARD:  cfg_next.esc_forward_max_us = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steer_center_us    <= RST_STEER_CENTER;
            cfg_reg.steer_trim         <= '0;
            cfg_reg.left_range_pct     <= RST_RANGE_PCT;
            cfg_reg.right_range_pct    <= RST_RANGE_PCT;
            cfg_reg.esc_two_way        <= 1'b1;
            cfg_reg.esc_reverse_max_us <= RST_ESC_REVERSE;
            cfg_reg.esc_idle_us        <= RST_ESC_NEUTRAL;
            cfg_reg.esc_forward_max_us <= RST_ESC_FORWARD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/scs_muldiv100.sv]
// ----------------------------------------------------------------------------
// scs_muldiv100
// Shared arithmetic unit: trunc(a * b / 100) toward zero in three stages
// (product, reciprocal scaling of the magnitude, sign restore).
// ----------------------------------------------------------------------------
module scs_muldiv100
    import scs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scs_mreq_t req,
    output scs_mrsp_t rsp
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [MAG_W-1:0]         mag_w;
    logic [SCALED_W-1:0]      scaled_reg;
    logic [SCALED_W-1:0]      scaled_next;
    logic                     neg_reg;
    logic [QUO_W-1:0]         quo_mag_w;
    logic signed [QUO_W-1:0]  quo_reg;
    logic signed [QUO_W-1:0]  quo_next;
    logic                     v1_reg;
    logic                     v2_reg;
    logic                     done_reg;

    always_comb
    begin
        prod_next   = PROD_W'(req.a) * PROD_W'(req.b);
        // magnitude of the product; the most negative code is never reached
        mag_w       = prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
        scaled_next = SCALED_W'(mag_w) * SCALED_W'(RECIP_100);
        quo_mag_w   = scaled_reg[RECIP_SHIFT +: QUO_W];
        quo_next    = neg_reg ? -$signed(quo_mag_w) : $signed(quo_mag_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
        neg_reg    <= prod_reg[PROD_W-1];
        quo_reg    <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for servo_command_shaper. Throttle and steering
// commands are streamed in while the bench mirrors the shaper in its own
// predictor: steering center with trim, per-side travel, hold band, slew
// limit, and the ESC mapping in both modes. Every result item is compared
// field by field with the oldest predicted pulse set. Register settings
// change only between phases, with the block drained.
// ----------------------------------------------------------------------------
module tb;
    import scs_pkg::*;

    // Cycles without any handshake before the run is declared hung. The
    // slowest legal gap is the long receiver hold plus one item time.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_PCT = 24;

    typedef struct {
        logic [11:0] steer_us;
        logic        changed;
        logic [11:0] esc_us;
    } pulse_set_t;

    logic                  clk;
    logic                  rst_n;
    // input items: [7:0] throttle_pct, [15:8] steer_pct
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    // result items: [11:0] steer_pulse_us, [12] steer_changed,
    // [24:13] esc_pulse_us, [31:25] zero
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Mirror of the block: register file and applied steering pulse
    scs_cfg_t   shaper_cfg;
    int         steer_now_us;
    pulse_set_t expected_pulses[$];

    // Stimulus bookkeeping
    logic [7:0] last_steer;
    bit         steady;          // suppress random idling on both sides
    int         hold_off_asked;  // written by the test sequence only
    int         hold_off_served; // written by the receiver only
    int         hold_left;
    int         commands_sent;
    int         results_checked;
    int         steer_updates;
    int         settings_loaded;
    int         mismatches;
    int         quiet_cycles;
    pulse_set_t got_pulses;
    pulse_set_t want_pulses;

    servo_command_shaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int clip(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the mirrored steering state by one command and return the
    // pulse set the block must produce for it.
    function automatic pulse_set_t shape_command(logic [7:0] thr_raw, logic [7:0] str_raw);
        int thr, str, trim, center, lpct, rpct, span_l, span_r;
        int target, delta, neutral, fwd, rev, esc;
        pulse_set_t r;
        thr = clip(int'($signed(thr_raw)), -PCT_MAX, PCT_MAX);
        str = clip(int'($signed(str_raw)), -PCT_MAX, PCT_MAX);
        // Load unsigned fields into ints first so the sums stay signed
        trim = $signed(shaper_cfg.steer_trim);
        center = shaper_cfg.steer_center_us;
        lpct = shaper_cfg.left_range_pct;
        rpct = shaper_cfg.right_range_pct;
        neutral = shaper_cfg.esc_idle_us;
        fwd = shaper_cfg.esc_forward_max_us;
        rev = shaper_cfg.esc_reverse_max_us;

        center = clip(center + trim * TRIM_STEP_US, CENTER_LO, CENTER_HI);
        span_l = ((center - STEER_LIMIT_LOW) * clip(lpct, 0, PCT_MAX)) / PCT_MAX;
        span_r = ((STEER_LIMIT_HIGH - center) * clip(rpct, 0, PCT_MAX)) / PCT_MAX;
        if (str >= 0)
            target = center + (span_r * str) / PCT_MAX;
        else
            target = center + (span_l * str) / PCT_MAX;
        target = clip(target, STEER_LIMIT_LOW, STEER_LIMIT_HIGH);

        // Follow the target only outside the hold band, at most one slew step
        delta = target - steer_now_us;
        r.changed = 1'b0;
        if (delta > HOLD_BAND_US || delta < -HOLD_BAND_US)
        begin
            steer_now_us = clip(steer_now_us + clip(delta, -MAX_SLEW_US, MAX_SLEW_US),
                                STEER_LIMIT_LOW, STEER_LIMIT_HIGH);
            r.changed = 1'b1;
        end

        // Forward-only mode reads negative throttle as zero
        if (shaper_cfg.esc_two_way && thr < 0)
            esc = neutral + ((neutral - rev) * thr) / PCT_MAX;
        else
            esc = neutral + ((fwd - neutral) * (thr < 0 ? 0 : thr)) / PCT_MAX;

        r.steer_us = 12'(steer_now_us);
        r.esc_us = 12'(esc);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] corner_pct();
        case ($urandom_range(10))
            0: return 8'h80;   // -128
            1: return 8'h9B;   // -101
            2: return 8'h9C;   // -100
            3: return 8'h9D;   // -99
            4: return 8'hFF;   // -1
            5: return 8'h00;
            6: return 8'h01;
            7: return 8'h63;   // 99
            8: return 8'h64;   // 100
            9: return 8'h65;   // 101
            default: return 8'h7F;
        endcase
    endfunction

    // Many small steering moves around the last command so the hold band
    // and slew limit see real traffic, plus full-range and corner values.
    function automatic logic [15:0] next_command();
        logic [7:0] thr, str;
        int pick;
        pick = $urandom_range(99);
        thr = 8'($urandom);
        if (pick < 35)
            str = 8'($urandom);
        else if (pick < 80)
            str = 8'(clip(int'($signed(last_steer)) + int'($urandom_range(24)) - 12, -128, 127));
        else
        begin
            str = corner_pct();
            thr = corner_pct();
        end
        last_steer = str;
        return {str, thr};
    endfunction

    function automatic logic [11:0] random_pulse();
        if ($urandom_range(99) < 80)
            return 12'($urandom_range(2500, 500));
        return 12'($urandom);
    endfunction

    function automatic logic [6:0] random_range_pct();
        case ($urandom_range(3))
            0: return 7'd0;
            1: return 7'd100;
            default: return 7'($urandom);
        endcase
    endfunction

    function automatic scs_cfg_t random_settings();
        scs_cfg_t c;
        case ($urandom_range(3))
            0: c.steer_center_us = 12'd500;
            1: c.steer_center_us = 12'd2500;
            2: c.steer_center_us = 12'($urandom_range(2500, 500));
            default: c.steer_center_us = 12'($urandom);
        endcase
        c.steer_trim = 7'($urandom);
        c.left_range_pct = random_range_pct();
        c.right_range_pct = random_range_pct();
        c.esc_two_way = 1'($urandom);
        c.esc_reverse_max_us = random_pulse();
        c.esc_idle_us = random_pulse();
        c.esc_forward_max_us = random_pulse();
        return c;
    endfunction

    // Write one register; called at a rising edge, returns after the edge at
    // which the block takes the write. Upper data bits carry junk the block must drop.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_STEER_CENTER: shaper_cfg.steer_center_us = val;
            REG_STEER_TRIM:   shaper_cfg.steer_trim = val[6:0];
            REG_LEFT_RANGE:   shaper_cfg.left_range_pct = val[6:0];
            REG_RIGHT_RANGE:  shaper_cfg.right_range_pct = val[6:0];
            REG_ESC_BIDIR:    shaper_cfg.esc_two_way = val[0];
            REG_ESC_REVERSE:  shaper_cfg.esc_reverse_max_us = val;
            REG_ESC_NEUTRAL:  shaper_cfg.esc_idle_us = val;
            REG_ESC_FORWARD:  shaper_cfg.esc_forward_max_us = val;
            default: ;
        endcase
    endtask

    // Load a full register set; only called with the block drained.
    task automatic load_settings(scs_cfg_t c);
        write_reg(REG_STEER_CENTER, c.steer_center_us);
        write_reg(REG_STEER_TRIM, {5'($urandom), c.steer_trim});
        write_reg(REG_LEFT_RANGE, {5'($urandom), c.left_range_pct});
        write_reg(REG_RIGHT_RANGE, {5'($urandom), c.right_range_pct});
        write_reg(REG_ESC_BIDIR, {11'($urandom), c.esc_two_way});
        write_reg(REG_ESC_REVERSE, c.esc_reverse_max_us);
        write_reg(REG_ESC_NEUTRAL, c.esc_idle_us);
        write_reg(REG_ESC_FORWARD, c.esc_forward_max_us);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Offer one command and hold it until taken. Valid stays high after the
    // handshake so back-to-back items need no extra edge.
    task automatic send_item(logic [7:0] thr, logic [7:0] str);
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {str, thr};
        do
            @(posedge clk);
        while (!s_tready);
        expected_pulses.push_back(shape_command(thr, str));
        commands_sent++;
    endtask

    task automatic run_commands(int n);
        logic [15:0] cmd;
        repeat (n)
        begin
            cmd = next_command();
            send_item(cmd[7:0], cmd[15:8]);
        end
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: command corners, hold band edge, slew toward both limits
    task automatic test_reset_defaults();
        send_item(8'd0, 8'd0);        // centered, nothing to do
        send_item(8'd0, 8'd1);        // target inside the hold band
        send_item(8'd0, 8'd2);        // just outside, small move
        send_item(8'd127, 8'd127);    // over range, clamped and slew limited
        send_item(8'd100, 8'd100);
        send_item(8'd101, 8'd101);
        send_item(8'd100, 8'd100);
        send_item(8'h80, 8'h80);      // under range, reverse direction
        send_item(8'h9C, 8'h9C);      // -100
        send_item(8'h9B, 8'h9B);      // -101
        send_item(8'hFF, 8'd1);
        send_item(8'd1, 8'hFF);
        send_item(8'd50, 8'hCE);      // 50, -50
        send_item(8'hCE, 8'd50);
        send_item(8'd99, 8'h9D);      // 99, -99
        send_item(8'h9D, 8'd99);
        drain();
    endtask

    // Register extremes: out-of-range center, trim at both ends, range
    // percentages at 0 and above 100, ESC endpoints on either side.
    task automatic test_register_extremes();
        load_settings(scs_cfg_t'{12'd2500, 7'sd63, 7'd127, 7'd0, 1'b0,
                                 12'd500, 12'd2500, 12'd500});
        run_commands(40);
        drain();
        load_settings(scs_cfg_t'{12'd500, -7'sd64, 7'd0, 7'd127, 1'b1,
                                 12'd4095, 12'd0, 12'd4095});
        run_commands(40);
        drain();
        load_settings(scs_cfg_t'{12'd4095, -7'sd50, 7'd100, 7'd100, 1'b1,
                                 12'd2500, 12'd500, 12'd2500});
        run_commands(40);
        drain();
        load_settings(scs_cfg_t'{12'd0, 7'sd50, 7'd1, 7'd99, 1'b1,
                                 12'd0, 12'd4095, 12'd0});
        run_commands(40);
        drain();
    endtask

    // Forward-only ESC: negative throttle must read as neutral
    task automatic test_forward_only();
        load_settings(scs_cfg_t'{12'd1500, 7'sd0, 7'd100, 7'd100, 1'b0,
                                 12'd1000, 12'd1500, 12'd2000});
        send_item(8'h80, 8'd0);
        send_item(8'hFF, 8'd0);
        send_item(8'd1, 8'd0);
        send_item(8'd127, 8'd0);
        run_commands(36);
        drain();
    endtask

    task automatic test_random_settings(int phases, int per_phase);
        repeat (phases)
        begin
            load_settings(random_settings());
            run_commands(per_phase);
            drain();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing,
    // so the output register and pipe fill and s_tready must drop.
    task automatic test_output_stall();
        steady = 1'b1;
        hold_off_asked++;
        run_commands(80);
        drain();
        steady = 1'b0;
    endtask

    // Long stretch with neither side idling: full-rate throughput
    task automatic test_full_rate();
        load_settings(random_settings());
        steady = 1'b1;
        run_commands(200);
        drain();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_STEER_CENTER;
        cfg_wdata = '0;
        steady = 1'b0;
        hold_off_asked = 0;
        commands_sent = 0;
        settings_loaded = 0;
        last_steer = '0;
        shaper_cfg = scs_cfg_t'{RST_STEER_CENTER, 7'sd0, RST_RANGE_PCT, RST_RANGE_PCT, 1'b1,
                                RST_ESC_REVERSE, RST_ESC_NEUTRAL, RST_ESC_FORWARD};
        steer_now_us = RST_APPLIED;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_forward_only();
        test_random_settings(14, 90);
        test_output_stall();
        test_full_rate();

        // Catch any stray result after the last one expected
        repeat (40) @(posedge clk);

        $display("tb: %0d commands over %0d register settings, %0d results checked",
                 commands_sent, settings_loaded, results_checked);
        $display("tb: %0d steering updates, %0d mismatches", steer_updates, mismatches);
        if (mismatches == 0 && expected_pulses.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, with long hold-offs on request
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        hold_off_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_served < hold_off_asked)
            begin
                hold_off_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------------
    initial
    begin
        mismatches = 0;
        results_checked = 0;
        steer_updates = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got_pulses.steer_us = m_tdata[11:0];
            got_pulses.changed = m_tdata[12];
            got_pulses.esc_us = m_tdata[24:13];
            if (expected_pulses.size() == 0)
            begin
                if (mismatches < 10)
                    $display("tb: unexpected result steer=%0d changed=%0d esc=%0d at %0t",
                             got_pulses.steer_us, got_pulses.changed, got_pulses.esc_us,
                             $realtime);
                mismatches++;
            end
            else
            begin
                want_pulses = expected_pulses.pop_front();
                results_checked++;
                if (want_pulses.changed)
                    steer_updates++;
                if (got_pulses.steer_us !== want_pulses.steer_us
                    || got_pulses.changed !== want_pulses.changed
                    || got_pulses.esc_us !== want_pulses.esc_us)
                begin
                    if (mismatches < 10)
                        $display({"tb: result %0d mismatch: steer %0d/%0d",
                                  " changed %0d/%0d esc %0d/%0d (expected/actual)"},
                                 results_checked,
                                 want_pulses.steer_us, got_pulses.steer_us,
                                 want_pulses.changed, got_pulses.changed,
                                 want_pulses.esc_us, got_pulses.esc_us);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either side for too long
    // ------------------------------------------------------------------------
    initial
        quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
